>>> rtl/ray_plane_intersection_macros.svh
// Assertion macros for the ray/plane intersection block.
// Used by modules that have clk and rst_n in scope; no other dependencies.
`ifndef RAY_PLANE_INTERSECTION_MACROS_SVH
`define RAY_PLANE_INTERSECTION_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define RPI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ray_plane_intersection: check failed");

// Next-cycle implication, quiet during reset.
`define RPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ray_plane_intersection: check failed");

`endif

>>> rtl/rpi_pkg.sv
// Shared types and codes for the ray/plane intersection block.
// No dependencies.
package rpi_pkg;

  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int INUM_W      = 8;

  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [CFG_INDEX_W-1:0] reg_index_t;
  typedef logic [INUM_W-1:0]      inum_t;

  localparam status_t STATUS_NONE   = 2'd0;
  localparam status_t STATUS_HIT    = 2'd1;
  localparam status_t STATUS_BEHIND = 2'd2;

  localparam reg_index_t REG_GROUND_X = 3'd0;
  localparam reg_index_t REG_GROUND_Y = 3'd1;
  localparam reg_index_t REG_GROUND_Z = 3'd2;
  localparam reg_index_t REG_NORMAL_X = 3'd3;
  localparam reg_index_t REG_NORMAL_Y = 3'd4;
  localparam reg_index_t REG_NORMAL_Z = 3'd5;

  localparam inum_t INUM_PLANE = 8'd1;

endpackage

>>> rtl/rpi_div_cell.sv
// One restoring-division step for three lanes sharing one divisor.
// Passes divisor and side data to the next cell; no package dependencies.
module rpi_div_cell #(
  parameter int DIV_W  = 66,
  parameter int ACC_W  = 101,
  parameter int SIDE_W = 200
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [DIV_W-1:0]       in_div,
  input  logic [2:0][ACC_W-1:0]  in_acc,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_valid,
  output logic [DIV_W-1:0]       out_div,
  output logic [2:0][ACC_W-1:0]  out_acc,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int RW = DIV_W + 1;
  localparam int K  = ACC_W - RW;

  logic                  valid_r;
  logic [DIV_W-1:0]      div_r;
  logic [2:0][ACC_W-1:0] acc_r, acc_nxt;
  logic [SIDE_W-1:0]     side_r;

  always_comb begin
    logic [ACC_W-1:0] sh;
    logic [RW-1:0]    top;
    acc_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      sh  = {in_acc[i][ACC_W-2:0], 1'b0};
      top = sh[ACC_W-1:K];
      if (top >= {1'b0, in_div}) begin
        acc_nxt[i] = {top - {1'b0, in_div}, sh[K-1:1], 1'b1};
      end else begin
        acc_nxt[i] = sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= in_div;
      acc_r  <= acc_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_div   = div_r;
  assign out_acc   = acc_r;
  assign out_side  = side_r;

endmodule

>>> rtl/ray_plane_intersection.sv
// Ray/plane intersection, one ray per cycle while out_ready allows, fully pipelined.
// An input transfer passes stages 0 to 4, the division chain and the output register.
// Throughput: one ray per cycle when not stalled; the quotient is formed by a chain of
// COORD_WIDTH+2 division cells, one quotient bit per cell, all three axes in parallel.
// Reset (rst_n, synchronous, active low) empties the pipe and sets the plane to
// ground = 0, normal = (0, 0, 1.0).
module ray_plane_intersection #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  rpi_pkg::reg_index_t             cfg_index,
  input  logic signed [COORD_WIDTH-1:0]   cfg_data,
  // ray input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   in_origin_x,
  input  logic signed [COORD_WIDTH-1:0]   in_origin_y,
  input  logic signed [COORD_WIDTH-1:0]   in_origin_z,
  input  logic signed [COORD_WIDTH-1:0]   in_dir_x,
  input  logic signed [COORD_WIDTH-1:0]   in_dir_y,
  input  logic signed [COORD_WIDTH-1:0]   in_dir_z,
  input  rpi_pkg::inum_t                  in_intercept_number,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [COORD_WIDTH-1:0]   out_hit_x,
  output logic signed [COORD_WIDTH-1:0]   out_hit_y,
  output logic signed [COORD_WIDTH-1:0]   out_hit_z,
  output rpi_pkg::status_t                out_hit_status
);

  import rpi_pkg::*;

  `include "ray_plane_intersection_macros.svh"

  localparam int W    = COORD_WIDTH;
  localparam int PW   = 2 * W;          // dir * normal product
  localparam int GW   = W + 1;          // ground - origin
  localparam int GNW  = 2 * W + 1;      // (ground - origin) * normal
  localparam int DW   = 2 * W + 2;      // dot
  localparam int NW   = 2 * W + 3;      // num
  localparam int NHW  = NW - W;         // upper slice of |num|
  localparam int PMW  = 3 * W + 3;      // |dir * num|
  localparam int K    = W + 2;          // quotient bits kept before saturation
  localparam int RW   = DW + 1;         // partial remainder
  localparam int AW   = RW + K;         // cell accumulator
  localparam int SUMW = K + 2;          // origin +/- quotient
  localparam int SW   = 6 * W + STATUS_W + 6;
  localparam int NCELL = K;

  localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Plane regs, read live by the pipe: user must write only while idle, not enforced.
  // ---------------------------------------------------------------------------
  logic signed [2:0][W-1:0] ground_r;
  logic signed [2:0][W-1:0] normal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_r <= '0;
      normal_r <= {W'(64'd1 << FRACTION_BITS), {W{1'b0}}, {W{1'b0}}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUND_X: ground_r[0] <= cfg_data;
        REG_GROUND_Y: ground_r[1] <= cfg_data;
        REG_GROUND_Z: ground_r[2] <= cfg_data;
        REG_NORMAL_X: normal_r[0] <= cfg_data;
        REG_NORMAL_Y: normal_r[1] <= cfg_data;
        REG_NORMAL_Z: normal_r[2] <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipe advances whenever the output register can
  // take what reaches it. Bubbles travel with the pipe.
  // ---------------------------------------------------------------------------
  logic       en;
  logic [4:0] pipe_v_r;
  logic       out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= '0;
    end else if (en) begin
      pipe_v_r <= {pipe_v_r[3:0], in_valid};
    end
  end

  // Stage 0: capture the ray.
  logic signed [2:0][W-1:0] o0_r, d0_r;
  inum_t                    inum0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      o0_r    <= {in_origin_z, in_origin_y, in_origin_x};
      d0_r    <= {in_dir_z, in_dir_y, in_dir_x};
      inum0_r <= in_intercept_number;
    end
  end

  // Stage 1: per-axis products for dot and num.
  logic signed [PW-1:0]  dn1_r  [3];
  logic signed [GNW-1:0] gn1_r  [3];
  logic signed [2:0][W-1:0] o1_r, d1_r;
  logic                  inok1_r;

  always_ff @(posedge clk) begin
    logic signed [GW-1:0] diff;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        diff     = GW'($signed(ground_r[i])) - GW'($signed(o0_r[i]));
        dn1_r[i] <= PW'($signed(d0_r[i])) * PW'($signed(normal_r[i]));
        gn1_r[i] <= GNW'(diff) * GNW'($signed(normal_r[i]));
      end
      o1_r    <= o0_r;
      d1_r    <= d0_r;
      inok1_r <= (inum0_r == INUM_PLANE);
    end
  end

  // Stage 2: sum into dot and num, classify, take magnitudes.
  logic signed [DW-1:0] dot2;
  logic signed [NW-1:0] num2;
  status_t              st2_nxt;

  always_comb begin
    dot2 = DW'(dn1_r[0]) + DW'(dn1_r[1]) + DW'(dn1_r[2]);
    num2 = NW'(gn1_r[0]) + NW'(gn1_r[1]) + NW'(gn1_r[2]);
    priority if (!inok1_r) begin
      st2_nxt = STATUS_NONE;
    end else if (dot2 == '0) begin
      st2_nxt = STATUS_NONE;
    end else if (num2 != '0 && (num2[NW-1] != dot2[DW-1])) begin
      st2_nxt = STATUS_BEHIND;
    end else begin
      st2_nxt = STATUS_HIT;
    end
  end

  logic [DW-1:0]            dmag2_r;
  logic [NW-1:0]            nmag2_r;
  logic                     qneg2_r;
  status_t                  st2_r;
  logic signed [2:0][W-1:0] o2_r, d2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dmag2_r <= dot2[DW-1] ? DW'(-dot2) : DW'(dot2);
      nmag2_r <= num2[NW-1] ? NW'(-num2) : NW'(num2);
      qneg2_r <= num2[NW-1] ^ dot2[DW-1];
      st2_r   <= st2_nxt;
      o2_r    <= o1_r;
      d2_r    <= d1_r;
    end
  end

  // Stage 3: |dir| * |num| as two partial products per axis.
  logic [2*W-1:0]           pl3_r [3];
  logic [W+NHW-1:0]         ph3_r [3];
  logic [2:0]               neg3_r;
  logic [DW-1:0]            dmag3_r;
  status_t                  st3_r;
  logic signed [2:0][W-1:0] o3_r, d3_r;

  always_ff @(posedge clk) begin
    logic [W-1:0] dabs;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dabs      = d2_r[i][W-1] ? W'(-d2_r[i]) : W'(d2_r[i]);
        pl3_r[i]  <= (2*W)'(dabs) * (2*W)'(nmag2_r[W-1:0]);
        ph3_r[i]  <= (W+NHW)'(dabs) * (W+NHW)'(nmag2_r[NW-1:W]);
        neg3_r[i] <= d2_r[i][W-1] ^ qneg2_r;
      end
      dmag3_r <= dmag2_r;
      st3_r   <= st2_r;
      o3_r    <= o2_r;
      d3_r    <= d2_r;
    end
  end

  // Stage 4: combine partial products.
  logic [2:0][PMW-1:0]      pmag4_r;
  logic [2:0]               neg4_r;
  logic [DW-1:0]            dmag4_r;
  status_t                  st4_r;
  logic signed [2:0][W-1:0] o4_r, d4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pmag4_r[i] <= (PMW'(ph3_r[i]) << W) + PMW'(pl3_r[i]);
      end
      neg4_r  <= neg3_r;
      dmag4_r <= dmag3_r;
      st4_r   <= st3_r;
      o4_r    <= o3_r;
      d4_r    <= d3_r;
    end
  end

  // Quotient beyond K bits always saturates: flag it before the cells.
  logic [2:0]            ovf4;
  logic [2:0][AW-1:0]    acc_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ovf4[i]   = DW'(pmag4_r[i][PMW-1:K]) >= dmag4_r;
      acc_in[i] = AW'(pmag4_r[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // Division chain: one quotient bit per cell, MSB first.
  // ---------------------------------------------------------------------------
  logic                  cv   [NCELL+1];
  logic [DW-1:0]         cdiv [NCELL+1];
  logic [2:0][AW-1:0]    cacc [NCELL+1];
  logic [SW-1:0]         cside[NCELL+1];

  assign cv[0]    = pipe_v_r[4];
  assign cdiv[0]  = dmag4_r;
  assign cacc[0]  = acc_in;
  assign cside[0] = {ovf4, neg4_r, st4_r, o4_r, d4_r};

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    rpi_div_cell #(
      .DIV_W  (DW),
      .ACC_W  (AW),
      .SIDE_W (SW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cv[j]),
      .in_div    (cdiv[j]),
      .in_acc    (cacc[j]),
      .in_side   (cside[j]),
      .out_valid (cv[j+1]),
      .out_div   (cdiv[j+1]),
      .out_acc   (cacc[j+1]),
      .out_side  (cside[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Final: origin +/- quotient, saturate, pick point or direction.
  // ---------------------------------------------------------------------------
  logic [2:0]               f_ovf, f_neg;
  status_t                  f_st;
  logic signed [2:0][W-1:0] f_o, f_d;
  logic signed [2:0][W-1:0] hit_nxt;

  assign {f_ovf, f_neg, f_st, f_o, f_d} = cside[NCELL];

  always_comb begin
    logic signed [SUMW-1:0] s;
    logic signed [SUMW-1:0] qx;
    logic signed [W-1:0]    pt;
    hit_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      qx = $signed(SUMW'(cacc[NCELL][i][K-1:0]));
      s  = f_neg[i] ? (SUMW'($signed(f_o[i])) - qx) : (SUMW'($signed(f_o[i])) + qx);
      priority if (f_ovf[i]) begin
        pt = f_neg[i] ? SAT_MIN : SAT_MAX;
      end else if (!s[SUMW-1] && (|s[SUMW-1:W-1])) begin
        pt = SAT_MAX;
      end else if (s[SUMW-1] && !(&s[SUMW-1:W-1])) begin
        pt = SAT_MIN;
      end else begin
        pt = s[W-1:0];
      end
      hit_nxt[i] = (f_st == STATUS_HIT) ? pt : f_d[i];
    end
  end

  // Output register: hold until the consumer takes the transfer.
  logic signed [2:0][W-1:0] hit_r;
  status_t                  status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (en && cv[NCELL]) begin
      hit_r    <= hit_nxt;
      status_r <= f_st;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit_x      = hit_r[0];
  assign out_hit_y      = hit_r[1];
  assign out_hit_z      = hit_r[2];
  assign out_hit_status = status_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `RPI_ASSERT_IMPL(a_hit_has_divisor, pipe_v_r[2] && st2_r == STATUS_HIT, dmag2_r != '0)
  `RPI_ASSERT_NEXT(a_chain_lands, en && cv[NCELL], out_valid_r)
  `RPI_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(pipe_v_r))

endmodule
